FILE: hdl/udc_pkg.sv
// Shared types, byte-class constants and the diacritic composition table.
`timescale 1ns / 1ps

package udc_pkg;

  // UTF-8 lead and continuation byte classes
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] LEAD5_MASK = 8'hFC;
  localparam logic [7:0] LEAD5_CODE = 8'hF8;
  localparam logic [7:0] LEAD6_MASK = 8'hFE;
  localparam logic [7:0] LEAD6_CODE = 8'hFC;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  // Combining marks
  localparam logic [15:0] MARK_GRAVE   = 16'h0300;
  localparam logic [15:0] MARK_ACUTE   = 16'h0301;
  localparam logic [15:0] MARK_CIRC    = 16'h0302;
  localparam logic [15:0] MARK_TILDE   = 16'h0303;
  localparam logic [15:0] MARK_BREVE   = 16'h0306;
  localparam logic [15:0] MARK_UMLAUT  = 16'h0308;
  localparam logic [15:0] MARK_RING    = 16'h030A;
  localparam logic [15:0] MARK_CARON   = 16'h030C;
  localparam logic [15:0] MARK_CEDILLA = 16'h0327;

  // Decoder and hold-window state
  typedef struct packed {
    logic [2:0]  pending;   // continuation bytes still due
    logic [30:0] acc;       // code point being assembled
    logic [1:0]  held_cnt;  // valid entries in the hold window
    logic [7:0]  held0;     // oldest held byte
    logic [7:0]  held1;
  } udc_state_t;

  // One output beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } udc_item_t;

  // Beats produced by one input byte, in order
  typedef struct packed {
    logic [1:0]           cnt;
    udc_item_t [2:0]      items;
  } udc_emit_t;

  // Precomposed code point for a mark and base letter, 0 when no pair exists
  function automatic logic [8:0] udc_lookup(input logic [15:0] mark,
                                            input logic [7:0] letter);
    logic [8:0] cp;
    cp = 9'd0;
    unique case (mark)
      MARK_GRAVE: begin
        unique case (letter)
          "A": cp = 9'h0C0;  "E": cp = 9'h0C8;  "I": cp = 9'h0CC;  "O": cp = 9'h0D2;
          "U": cp = 9'h0D9;  "a": cp = 9'h0E0;  "e": cp = 9'h0E8;  "i": cp = 9'h0EC;
          "o": cp = 9'h0F2;  "u": cp = 9'h0F9;
          default: cp = 9'd0;
        endcase
      end
      MARK_ACUTE: begin
        unique case (letter)
          "A": cp = 9'h0C1;  "C": cp = 9'h106;  "E": cp = 9'h0C9;  "I": cp = 9'h0CD;
          "L": cp = 9'h139;  "N": cp = 9'h143;  "O": cp = 9'h0D3;  "R": cp = 9'h154;
          "S": cp = 9'h15A;  "U": cp = 9'h0DA;  "Y": cp = 9'h0DD;  "Z": cp = 9'h179;
          "a": cp = 9'h0E1;  "c": cp = 9'h107;  "e": cp = 9'h0E9;  "i": cp = 9'h0ED;
          "l": cp = 9'h13A;  "n": cp = 9'h144;  "o": cp = 9'h0F3;  "r": cp = 9'h155;
          "s": cp = 9'h15B;  "u": cp = 9'h0FA;  "y": cp = 9'h0FD;  "z": cp = 9'h17A;
          default: cp = 9'd0;
        endcase
      end
      MARK_CIRC: begin
        unique case (letter)
          "A": cp = 9'h0C2;  "C": cp = 9'h108;  "E": cp = 9'h0CA;  "G": cp = 9'h11C;
          "H": cp = 9'h124;  "I": cp = 9'h0CE;  "J": cp = 9'h134;  "O": cp = 9'h0D4;
          "S": cp = 9'h15C;  "U": cp = 9'h0DB;  "W": cp = 9'h174;  "Y": cp = 9'h176;
          "a": cp = 9'h0E2;  "c": cp = 9'h109;  "e": cp = 9'h0EA;  "g": cp = 9'h11D;
          "h": cp = 9'h125;  "i": cp = 9'h0EE;  "j": cp = 9'h135;  "o": cp = 9'h0F4;
          "s": cp = 9'h15D;  "u": cp = 9'h0FB;  "w": cp = 9'h175;  "y": cp = 9'h177;
          default: cp = 9'd0;
        endcase
      end
      MARK_TILDE: begin
        unique case (letter)
          "A": cp = 9'h0C3;  "I": cp = 9'h128;  "N": cp = 9'h0D1;  "O": cp = 9'h0D5;
          "U": cp = 9'h168;  "a": cp = 9'h0E3;  "i": cp = 9'h129;  "n": cp = 9'h0F1;
          "o": cp = 9'h0F5;  "u": cp = 9'h169;
          default: cp = 9'd0;
        endcase
      end
      MARK_BREVE: begin
        unique case (letter)
          "A": cp = 9'h102;  "E": cp = 9'h114;  "G": cp = 9'h11E;  "I": cp = 9'h12C;
          "O": cp = 9'h14E;  "U": cp = 9'h16C;  "a": cp = 9'h103;  "e": cp = 9'h115;
          "g": cp = 9'h11F;  "i": cp = 9'h12D;  "o": cp = 9'h14F;  "u": cp = 9'h16D;
          default: cp = 9'd0;
        endcase
      end
      MARK_UMLAUT: begin
        unique case (letter)
          "A": cp = 9'h0C4;  "E": cp = 9'h0CB;  "I": cp = 9'h0CF;  "O": cp = 9'h0D6;
          "U": cp = 9'h0DC;  "Y": cp = 9'h178;  "a": cp = 9'h0E4;  "e": cp = 9'h0EB;
          "i": cp = 9'h0EF;  "o": cp = 9'h0F6;  "u": cp = 9'h0FC;  "y": cp = 9'h0FF;
          default: cp = 9'd0;
        endcase
      end
      MARK_RING: begin
        unique case (letter)
          "A": cp = 9'h0C5;  "U": cp = 9'h16E;  "a": cp = 9'h0E5;  "u": cp = 9'h16F;
          default: cp = 9'd0;
        endcase
      end
      MARK_CARON: begin
        unique case (letter)
          "C": cp = 9'h10C;  "D": cp = 9'h10E;  "E": cp = 9'h11A;  "N": cp = 9'h147;
          "R": cp = 9'h158;  "S": cp = 9'h160;  "T": cp = 9'h164;  "Z": cp = 9'h17D;
          "c": cp = 9'h10D;  "d": cp = 9'h10F;  "e": cp = 9'h11B;  "n": cp = 9'h148;
          "r": cp = 9'h159;  "s": cp = 9'h161;  "t": cp = 9'h165;  "z": cp = 9'h17E;
          default: cp = 9'd0;
        endcase
      end
      MARK_CEDILLA: begin
        unique case (letter)
          "C": cp = 9'h0C7;  "c": cp = 9'h0E7;
          default: cp = 9'd0;
        endcase
      end
      default: cp = 9'd0;
    endcase
    return cp;
  endfunction

endpackage

FILE: hdl/udc_step.sv
// Per-byte UTF-8 decode, mark composition and hold-window update.
`timescale 1ns / 1ps

module udc_step (
  input  udc_pkg::udc_state_t cur,
  input  logic [7:0]          in_byte,
  input  logic                end_of_string,
  output udc_pkg::udc_state_t nxt,
  output udc_pkg::udc_emit_t  emit
);
  import udc_pkg::*;

  logic [30:0] acc_cont;
  logic [8:0]  cp;
  logic        composed;
  logic [7:0]  p0, p1;
  logic [1:0]  pn, fn, total;

  assign acc_cont = {cur.acc[24:0], in_byte[5:0]};

  always_comb begin
    nxt      = cur;
    cp       = 9'd0;
    composed = 1'b0;
    p0       = 8'd0;
    p1       = 8'd0;
    pn       = 2'd0;

    // decoder: lead byte, continuation, or broken sequence
    if (cur.pending == 3'd0) begin
      priority if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
        nxt.acc = {26'd0, in_byte[4:0]};  nxt.pending = 3'd1;
      end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
        nxt.acc = {27'd0, in_byte[3:0]};  nxt.pending = 3'd2;
      end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
        nxt.acc = {28'd0, in_byte[2:0]};  nxt.pending = 3'd3;
      end else if ((in_byte & LEAD5_MASK) == LEAD5_CODE) begin
        nxt.acc = {29'd0, in_byte[1:0]};  nxt.pending = 3'd4;
      end else if ((in_byte & LEAD6_MASK) == LEAD6_CODE) begin
        nxt.acc = {30'd0, in_byte[0]};    nxt.pending = 3'd5;
      end else begin
        nxt.pending = 3'd0;
      end
    end else if ((in_byte & CONT_MASK) == CONT_CODE) begin
      nxt.acc     = acc_cont;
      nxt.pending = cur.pending - 3'd1;
      // completed mark with letter two places back
      if (nxt.pending == 3'd0 && cur.held_cnt == 2'd2) begin
        cp       = (acc_cont[30:16] == 15'd0) ? udc_lookup(acc_cont[15:0], cur.held0)
                                              : 9'd0;
        composed = (cp != 9'd0);
      end
    end else begin
      nxt.pending = 3'd0;
    end

    // hold window
    if (composed) begin
      p0           = {5'b11000, cp[8:6]};
      p1           = {2'b10, cp[5:0]};
      pn           = 2'd2;
      nxt.held_cnt = 2'd0;
    end else begin
      unique case (cur.held_cnt)
        2'd0: begin
          nxt.held0    = in_byte;
          nxt.held_cnt = 2'd1;
        end
        2'd1: begin
          nxt.held1    = in_byte;
          nxt.held_cnt = 2'd2;
        end
        default: begin
          p0           = cur.held0;
          pn           = 2'd1;
          nxt.held0    = cur.held1;
          nxt.held1    = in_byte;
          nxt.held_cnt = 2'd2;
        end
      endcase
    end

    // flush on end of string
    fn    = end_of_string ? nxt.held_cnt : 2'd0;
    total = pn + fn;

    emit.cnt            = total;
    emit.items[0].data  = (pn != 2'd0) ? p0 : nxt.held0;
    emit.items[1].data  = (pn == 2'd2) ? p1 : ((pn == 2'd1) ? nxt.held0 : nxt.held1);
    emit.items[2].data  = nxt.held1;
    emit.items[0].last  = end_of_string && (total == 2'd1);
    emit.items[1].last  = end_of_string && (total == 2'd2);
    emit.items[2].last  = end_of_string && (total == 2'd3);

    if (end_of_string) begin
      nxt.pending  = 3'd0;
      nxt.acc      = 31'd0;
      nxt.held_cnt = 2'd0;
    end
  end

endmodule

FILE: hdl/udc_outq.sv
// Collapsing output queue: takes up to three beats per push, gives one per pop.
`timescale 1ns / 1ps

module udc_outq #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  udc_pkg::udc_emit_t push_data,
  input  logic               pop,
  output logic               has_room,
  output logic               not_empty,
  output udc_pkg::udc_item_t head
);
  import udc_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  udc_item_t [DEPTH-1:0] slot;
  udc_item_t [DEPTH-1:0] slot_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         base;
  logic [CW-1:0]         add;

  assign base       = count - {{(CW-1){1'b0}}, pop};
  assign add        = push ? CW'(push_data.cnt) : '0;
  assign count_next = base + add;
  assign has_room   = (count <= CW'(DEPTH - 3));
  assign not_empty  = (count != '0);
  assign head       = slot[0];

  // each slot either shifts down, keeps, or takes a new beat
  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    localparam logic [CW-1:0] POS = CW'(g);
    logic [CW-1:0] k;
    udc_item_t     above;
    if (g < DEPTH - 1) begin : g_above
      assign above = slot[g+1];
    end else begin : g_top
      assign above = slot[g];
    end
    assign k = POS - base;
    always_comb begin
      slot_next[g] = slot[g];
      if (POS < base) begin
        slot_next[g] = pop ? above : slot[g];
      end else if (push && (k < CW'(push_data.cnt))) begin
        slot_next[g] = push_data.items[k[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

FILE: hdl/utf8_diacritic_composer.sv
// Top level: UTF-8 combining-mark composer with output beat queue.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid, in_stall, in_byte, end_of_string | in, stall out
//  output  | out_valid, out_stall, out_byte, last_byte  | out, stall in
//
// One input byte is taken per cycle while in_stall is low; each makes
// zero to three output beats, registered in an OUT_DEPTH-beat queue.
// in_stall is high while the queue has fewer than three free entries, so
// the output side sets the rate: one unstalled beat per cycle drains it.
// rst clears the decoder, the hold window and the queue; no clearing pass.
`timescale 1ns / 1ps

module utf8_diacritic_composer #(
  parameter int OUT_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_byte
);
  import udc_pkg::*;

  udc_state_t state;
  udc_state_t state_next;
  udc_emit_t  emit;
  udc_item_t  head;
  logic       accept;
  logic       has_room;
  logic       pop;

  assign in_stall = !has_room;
  assign accept   = in_valid && has_room;
  assign pop      = out_valid && !out_stall;

  // decode and compose one byte
  udc_step u_step (
    .cur           (state),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .nxt           (state_next),
    .emit          (emit)
  );

  // decoder control state and held bytes; held bytes need no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state.pending  <= 3'd0;
      state.acc      <= 31'd0;
      state.held_cnt <= 2'd0;
    end else if (accept) begin
      state.pending  <= state_next.pending;
      state.acc      <= state_next.acc;
      state.held_cnt <= state_next.held_cnt;
    end
    if (accept) begin
      state.held0 <= state_next.held0;
      state.held1 <= state_next.held1;
    end
  end

  // result beats
  udc_outq #(.DEPTH(OUT_DEPTH)) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (emit),
    .pop       (pop),
    .has_room  (has_room),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_byte  = head.data;
  assign last_byte = head.last;

endmodule

FILE: hdl/udc_checker.sv
// Port-level checks for the composer, bound to the top level.
`timescale 1ns / 1ps

module udc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       end_of_string,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_byte
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("output beat changed while stalled");

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(end_of_string))
    else $error("input beat changed while stalled");

  // reset empties the queue
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // reset leaves room for input
  a_rst_ready: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // beats only appear after a byte was taken
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("output beat with no accepted input");

endmodule

bind utf8_diacritic_composer udc_checker u_chk (.*);

FILE: tb/composer_check_pkg.sv
// Composition table and scoreboard used to check the UTF-8 diacritic composer.
`timescale 1ns / 1ps

package composer_check_pkg;

  import udc_pkg::*;

  // {mark low byte (mark = 0x03xx), base letter, precomposed code point}
  localparam logic [31:0] COMPOSE_TBL [114] = '{
    // grave
    {8'h00,"A",16'h0C0}, {8'h00,"E",16'h0C8}, {8'h00,"I",16'h0CC}, {8'h00,"O",16'h0D2},
    {8'h00,"U",16'h0D9}, {8'h00,"a",16'h0E0}, {8'h00,"e",16'h0E8}, {8'h00,"i",16'h0EC},
    {8'h00,"o",16'h0F2}, {8'h00,"u",16'h0F9},
    // acute
    {8'h01,"A",16'h0C1}, {8'h01,"C",16'h106}, {8'h01,"E",16'h0C9}, {8'h01,"I",16'h0CD},
    {8'h01,"L",16'h139}, {8'h01,"N",16'h143}, {8'h01,"O",16'h0D3}, {8'h01,"R",16'h154},
    {8'h01,"S",16'h15A}, {8'h01,"U",16'h0DA}, {8'h01,"Y",16'h0DD}, {8'h01,"Z",16'h179},
    {8'h01,"a",16'h0E1}, {8'h01,"c",16'h107}, {8'h01,"e",16'h0E9}, {8'h01,"i",16'h0ED},
    {8'h01,"l",16'h13A}, {8'h01,"n",16'h144}, {8'h01,"o",16'h0F3}, {8'h01,"r",16'h155},
    {8'h01,"s",16'h15B}, {8'h01,"u",16'h0FA}, {8'h01,"y",16'h0FD}, {8'h01,"z",16'h17A},
    // circumflex
    {8'h02,"A",16'h0C2}, {8'h02,"C",16'h108}, {8'h02,"E",16'h0CA}, {8'h02,"G",16'h11C},
    {8'h02,"H",16'h124}, {8'h02,"I",16'h0CE}, {8'h02,"J",16'h134}, {8'h02,"O",16'h0D4},
    {8'h02,"S",16'h15C}, {8'h02,"U",16'h0DB}, {8'h02,"W",16'h174}, {8'h02,"Y",16'h176},
    {8'h02,"a",16'h0E2}, {8'h02,"c",16'h109}, {8'h02,"e",16'h0EA}, {8'h02,"g",16'h11D},
    {8'h02,"h",16'h125}, {8'h02,"i",16'h0EE}, {8'h02,"j",16'h135}, {8'h02,"o",16'h0F4},
    {8'h02,"s",16'h15D}, {8'h02,"u",16'h0FB}, {8'h02,"w",16'h175}, {8'h02,"y",16'h177},
    // tilde
    {8'h03,"A",16'h0C3}, {8'h03,"I",16'h128}, {8'h03,"N",16'h0D1}, {8'h03,"O",16'h0D5},
    {8'h03,"U",16'h168}, {8'h03,"a",16'h0E3}, {8'h03,"i",16'h129}, {8'h03,"n",16'h0F1},
    {8'h03,"o",16'h0F5}, {8'h03,"u",16'h169},
    // breve
    {8'h06,"A",16'h102}, {8'h06,"E",16'h114}, {8'h06,"G",16'h11E}, {8'h06,"I",16'h12C},
    {8'h06,"O",16'h14E}, {8'h06,"U",16'h16C}, {8'h06,"a",16'h103}, {8'h06,"e",16'h115},
    {8'h06,"g",16'h11F}, {8'h06,"i",16'h12D}, {8'h06,"o",16'h14F}, {8'h06,"u",16'h16D},
    // umlaut
    {8'h08,"A",16'h0C4}, {8'h08,"E",16'h0CB}, {8'h08,"I",16'h0CF}, {8'h08,"O",16'h0D6},
    {8'h08,"U",16'h0DC}, {8'h08,"Y",16'h178}, {8'h08,"a",16'h0E4}, {8'h08,"e",16'h0EB},
    {8'h08,"i",16'h0EF}, {8'h08,"o",16'h0F6}, {8'h08,"u",16'h0FC}, {8'h08,"y",16'h0FF},
    // ring
    {8'h0A,"A",16'h0C5}, {8'h0A,"U",16'h16E}, {8'h0A,"a",16'h0E5}, {8'h0A,"u",16'h16F},
    // caron
    {8'h0C,"C",16'h10C}, {8'h0C,"D",16'h10E}, {8'h0C,"E",16'h11A}, {8'h0C,"N",16'h147},
    {8'h0C,"R",16'h158}, {8'h0C,"S",16'h160}, {8'h0C,"T",16'h164}, {8'h0C,"Z",16'h17D},
    {8'h0C,"c",16'h10D}, {8'h0C,"d",16'h10F}, {8'h0C,"e",16'h11B}, {8'h0C,"n",16'h148},
    {8'h0C,"r",16'h159}, {8'h0C,"s",16'h161}, {8'h0C,"t",16'h165}, {8'h0C,"z",16'h17E},
    // cedilla
    {8'h27,"C",16'h0C7}, {8'h27,"c",16'h0E7}
  };

  class composer_scoreboard;
    logic [2:0]  pending_cont = '0;  // continuation bytes still due
    logic [31:0] cp_acc = '0;        // code point being decoded
    logic [7:0]  window [2];         // held bytes, oldest first
    logic [1:0]  window_cnt = '0;
    udc_item_t   expected_beats [$];
    int          mismatch_count = 0;

    // Precomposed code point for mark + letter, 0 when the pair is unknown
    function logic [15:0] precomposed(logic [31:0] mark, logic [7:0] letter);
      foreach (COMPOSE_TBL[k]) begin
        if ({24'h000003, COMPOSE_TBL[k][31:24]} == mark && COMPOSE_TBL[k][23:16] == letter)
          return COMPOSE_TBL[k][15:0];
      end
      return 16'd0;
    endfunction

    // Work out the beats caused by one accepted input beat
    function void note_byte(logic [7:0] b, logic eos);
      logic [7:0]  step_bytes [$];
      logic [15:0] cp;
      udc_item_t   beat;
      bit          composed;
      composed = 0;

      // decoder
      if (pending_cont == 0) begin
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          cp_acc = {24'd0, b & ~LEAD2_MASK};
          pending_cont = 3'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
          cp_acc = {24'd0, b & ~LEAD3_MASK};
          pending_cont = 3'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
          cp_acc = {24'd0, b & ~LEAD4_MASK};
          pending_cont = 3'd3;
        end else if ((b & LEAD5_MASK) == LEAD5_CODE) begin
          cp_acc = {24'd0, b & ~LEAD5_MASK};
          pending_cont = 3'd4;
        end else if ((b & LEAD6_MASK) == LEAD6_CODE) begin
          cp_acc = {24'd0, b & ~LEAD6_MASK};
          pending_cont = 3'd5;
        end
      end else if ((b & CONT_MASK) == CONT_CODE) begin
        cp_acc = {cp_acc[25:0], b[5:0]};
        pending_cont = pending_cont - 3'd1;
        // a finished mark may fold into the letter two places back
        if (pending_cont == 0 && window_cnt == 2) begin
          cp = precomposed(cp_acc, window[0]);
          if (cp != 0) begin
            step_bytes.push_back({3'b110, cp[10:6]});
            step_bytes.push_back({2'b10, cp[5:0]});
            window_cnt = 2'd0;
            composed = 1;
          end
        end
      end else begin
        // bad continuation: drop the sequence, byte passes through
        pending_cont = 3'd0;
      end

      // hold window
      if (!composed) begin
        if (window_cnt == 2) begin
          step_bytes.push_back(window[0]);
          window[0] = window[1];
          window[1] = b;
        end else begin
          window[window_cnt] = b;
          window_cnt = window_cnt + 2'd1;
        end
      end

      // end of string flushes everything and restarts the decoder
      if (eos) begin
        for (int k = 0; k < window_cnt; k++) step_bytes.push_back(window[k]);
        window_cnt = 2'd0;
        pending_cont = 3'd0;
        cp_acc = '0;
      end

      foreach (step_bytes[k]) begin
        beat.data = step_bytes[k];
        beat.last = eos && (k == step_bytes.size() - 1);
        expected_beats.push_back(beat);
      end
    endfunction

    // Compare one accepted output beat with the oldest expectation
    function void check_beat(logic [7:0] data, logic last);
      udc_item_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got out_byte %02h last_byte %0b",
                 $time, data, last);
        mismatch_count++;
        return;
      end
      want = expected_beats.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %02h, got %02h", $time, want.data, data);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $display("%0t: last_byte expected %0b, got %0b", $time, want.last, last);
        mismatch_count++;
      end
    endfunction

    function int beats_due();
      return expected_beats.size();
    endfunction
  endclass

endpackage

FILE: tb/testbench.sv
// Self-checking testbench for the UTF-8 diacritic composer.
`timescale 1ns / 1ps

module testbench;

  import udc_pkg::*;
  import composer_check_pkg::*;

  localparam int STALL_LIMIT  = 1000;  // cycles with no beat moving
  localparam int TARGET_BYTES = 250;
  localparam int TAIL_CYCLES  = 20;

  // Token shapes for random strings
  typedef enum int {
    TK_PAIR, TK_ODD_PAIR, TK_ASCII, TK_MULTI, TK_NOISE, TK_LONG_MARK, TK_BARE_MARK
  } token_kind_t;

  // Opening strings, {end_of_string, byte}
  localparam logic [8:0] SAMPLE_TEXT [26] = '{
    9'h041, 9'h0CC, 9'h180,           // A + grave
    9'h044, 9'h0CC, 9'h18C,           // D + caron
    9'h063, 9'h0CC, 9'h1A7,           // c + cedilla
    9'h0CC, 9'h081,                   // mark with nothing before it
    9'h061, 9'h0CC, 9'h081,           // a + acute
    9'h0CC, 9'h081,                   // mark right after a composed char
    9'h061, 9'h0E0, 9'h08C, 9'h081,   // three-byte form of a mark
    9'h0C3, 9'h041,                   // broken continuation
    9'h080, 9'h0FE, 9'h000, 9'h1FF    // stray bytes and extremes
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       end_of_string;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       last_byte;

  composer_scoreboard sb;
  logic [7:0] text_bytes [$];
  bit         steady_run = 0;
  int         quiet_cycles = 0;

  utf8_diacritic_composer uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_byte     (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Present one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = steady_run ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_string <= eos;
    do @(posedge clk); while (in_stall);
  endtask

  // Append one random token to the string being built
  task automatic add_token();
    logic [31:0]  entry;
    logic [15:0]  mark;
    logic [7:0]   mark_lead;
    logic [7:0]   mark_tail;
    int           pick;
    int           len;
    token_kind_t  kind;
    entry     = COMPOSE_TBL[$urandom_range(0, 113)];
    mark      = {8'h03, entry[31:24]};
    mark_lead = {3'b110, mark[10:6]};
    mark_tail = {2'b10, mark[5:0]};
    pick      = $urandom_range(0, 9);
    kind      = (pick < 4) ? TK_PAIR : token_kind_t'(pick - 3);
    case (kind)
      TK_PAIR: begin
        text_bytes.push_back(entry[23:16]);
        text_bytes.push_back(mark_lead);
        text_bytes.push_back(mark_tail);
      end
      TK_ODD_PAIR: begin
        text_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
        text_bytes.push_back(mark_lead);
        text_bytes.push_back(mark_tail);
      end
      TK_ASCII: text_bytes.push_back(8'($urandom_range(0, 127)));
      TK_MULTI: begin
        // lead of a 2..6 byte form, continuations sometimes broken
        len = $urandom_range(2, 6);
        text_bytes.push_back((8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1))));
        repeat (len - 1) begin
          if ($urandom_range(0, 3) == 0) text_bytes.push_back(8'($urandom_range(0, 255)));
          else text_bytes.push_back({2'b10, 6'($urandom)});
        end
      end
      TK_NOISE: text_bytes.push_back(8'($urandom_range(0, 255)));
      TK_LONG_MARK: begin
        text_bytes.push_back(entry[23:16]);
        text_bytes.push_back({4'hE, mark[15:12]});
        text_bytes.push_back({2'b10, mark[11:6]});
        text_bytes.push_back(mark_tail);
      end
      TK_BARE_MARK: begin
        text_bytes.push_back(mark_lead);
        text_bytes.push_back(mark_tail);
      end
      default: text_bytes.push_back(8'h00);
    endcase
  endtask

  // Output side: random stall before each beat
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = steady_run ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(in_byte, end_of_string);
      if (out_valid && !out_stall) sb.check_beat(out_byte, last_byte);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("[utf8_diacritic_composer] ERROR");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int bytes_sent;
    int string_no;
    sb = new();
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    in_byte       <= 8'h00;
    end_of_string <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (SAMPLE_TEXT[k]) send_byte(SAMPLE_TEXT[k][7:0], SAMPLE_TEXT[k][8]);

    // random strings, each closed by end_of_string
    bytes_sent = 0;
    string_no  = 0;
    while (bytes_sent < TARGET_BYTES) begin
      text_bytes.delete();
      repeat ($urandom_range(1, 6)) add_token();
      steady_run = ($urandom_range(0, 4) == 0);
      if (string_no == 3) begin
        // let the block drain completely before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.beats_due() != 0) @(posedge clk);
      end
      foreach (text_bytes[k]) send_byte(text_bytes[k], k == text_bytes.size() - 1);
      bytes_sent += text_bytes.size();
      string_no++;
    end
    in_valid <= 1'b0;

    while (sb.beats_due() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.beats_due() == 0)
      $display("[utf8_diacritic_composer] OK");
    else
      $display("[utf8_diacritic_composer] ERROR");
    $finish;
  end

endmodule
